@@ hdl/one_shot_timer_bank_assert.svh @@
// ----------------------------------------------------------------------------
// One-shot timer bank assertion macros
// Concurrent assertion wrappers for the timer bank. Defining ASSERT_OFF
// turns every use into an empty statement.
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_TIMER_BANK_ASSERT_SVH
`define ONE_SHOT_TIMER_BANK_ASSERT_SVH

`ifndef ASSERT_OFF

// A property checked at every rising edge outside of reset.
`define OSTB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// An overlapping implication checked at every rising edge outside of reset.
`define OSTB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`else

`define OSTB_ASSERT(label, clk, rst, prop, msg)

`define OSTB_ASSERT_IMPL(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ hdl/ostb_pkg.sv @@
// ----------------------------------------------------------------------------
// One-shot timer bank package
// Field widths, operation codes, result kinds and the stored timer word.
// ----------------------------------------------------------------------------
package ostb_pkg;

  // Default number of channels in each bank.
  localparam int TIMER_COUNT_DEF = 5;

  // Field widths.
  localparam int OP_W    = 3;
  localparam int CH_W    = 4;
  localparam int PART_W  = 8;
  localparam int TAG_W   = 8;
  localparam int COUNT_W = 16;

  // Period scaling: one count is a tenth of a second.
  localparam int unsigned MINUTE_TICKS = 600;
  localparam int unsigned SECOND_TICKS = 10;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_SET    = 3'd2;
  localparam logic [OP_W-1:0] OP_START  = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd4;
  localparam logic [OP_W-1:0] OP_RESET  = 3'd5;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd6;

  // Result kinds.
  localparam logic KIND_CREATE = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // One entry of the timer memory.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] reload;
    logic [TAG_W-1:0]   tag;
  } timer_word_t;

endpackage

@@ hdl/ostb_period.sv @@
// ----------------------------------------------------------------------------
// Timer period converter
// Turns minutes, seconds and tenths into a count of tenths, modulo 2^16.
// ----------------------------------------------------------------------------
module ostb_period (
  input  logic [ostb_pkg::PART_W-1:0]  minutes,
  input  logic [ostb_pkg::PART_W-1:0]  seconds,
  input  logic [ostb_pkg::PART_W-1:0]  tenths,
  output logic [ostb_pkg::COUNT_W-1:0] period
);
  import ostb_pkg::*;

  localparam int MIN_W = PART_W + 10;
  localparam int SEC_W = PART_W + 4;

  logic [MIN_W-1:0] min_part;
  logic [SEC_W-1:0] sec_part;
  logic [MIN_W-1:0] total;

  // Scale each part, then add; the upper bits fall away in the final cut.
  assign min_part = MIN_W'(minutes) * MIN_W'(MINUTE_TICKS);
  assign sec_part = SEC_W'(seconds) * SEC_W'(SECOND_TICKS);
  assign total    = min_part + MIN_W'(sec_part) + MIN_W'(tenths);
  assign period   = total[COUNT_W-1:0];

endmodule

@@ hdl/one_shot_timer_bank.sv @@
// ----------------------------------------------------------------------------
// One-shot timer bank
// Two banks of one-shot countdown timers kept in a single timer memory.
// ----------------------------------------------------------------------------
// Usage: a command beat is taken at a rising edge with start high and busy
// low. Each command names an operation, a bank and, where it matters, a
// channel, the period parts or a tag. Results leave on the result ports,
// one beat per strobe cycle; the receiver cannot hold them off.
// Create, delete, set, start, stop and reset pass from the accept edge
// through a read state (S_RD) that fetches the channel's memory word and a
// write state (S_WR) that updates the word or the channel's flags, then return to
// idle for the next accept. The create answer is strobed in the cycle after
// the write. Tick walks the named bank one channel at a time, a read state
// (S_TRD) then a write state (S_TWR) per channel on the memory's read and write
// ports, and ends in the closing state S_TEND. Each expiry beat is held until
// the next expiry of the same tick or the closing state, so that the last one
// can be flagged; the final beat is strobed in the cycle after the closing state.
// Reset clears every enable, every claim and the written marks of the timer
// memory, so all channels read as free with zero counts, reloads and tags.
// ----------------------------------------------------------------------------
`include "one_shot_timer_bank_assert.svh"

module one_shot_timer_bank #(
  parameter int TIMER_COUNT = ostb_pkg::TIMER_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [ostb_pkg::OP_W-1:0]    opcode,
  input  logic                         bank,
  input  logic [ostb_pkg::CH_W-1:0]    channel,
  input  logic [ostb_pkg::PART_W-1:0]  minutes,
  input  logic [ostb_pkg::PART_W-1:0]  seconds,
  input  logic [ostb_pkg::PART_W-1:0]  tenths,
  input  logic [ostb_pkg::TAG_W-1:0]   tag,
  output logic                         strobe,
  output logic                         kind,
  output logic                         out_bank,
  output logic [ostb_pkg::CH_W-1:0]    out_channel,
  output logic                         ok,
  output logic [ostb_pkg::TAG_W-1:0]   out_tag,
  output logic                         last
);
  import ostb_pkg::*;

  localparam int SLOTS  = 2 * TIMER_COUNT;
  localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SUM_W  = CH_W + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_WR   = 6'b000100,
    S_TRD  = 6'b001000,
    S_TWR  = 6'b010000,
    S_TEND = 6'b100000
  } state_t;

  state_t state, state_next;

  // Latched command.
  logic [OP_W-1:0]    op_q;
  logic               bank_q;
  logic [CH_W-1:0]    ch_q;
  logic [PART_W-1:0]  min_q, sec_q, tenth_q;
  logic [TAG_W-1:0]   tag_q;
  logic [COUNT_W-1:0] period_calc, period_q;

  // Per-channel flags in flip-flops.
  logic [SLOTS-1:0] enabled;
  logic [SLOTS-1:0] claimed;
  logic [SLOTS-1:0] written;

  // Timer memory and its read port.
  timer_word_t      mem [SLOTS];
  timer_word_t      rd_word;
  logic             rd_live;
  timer_word_t      cur_word;

  // Tick scan and the held-back expiry beat.
  logic [CH_W-1:0]  scan_ch;
  logic             pend_v;
  logic [CH_W-1:0]  pend_ch;
  logic [TAG_W-1:0] pend_tag;
  logic             pend_load;

  // Access control.
  logic [TIMER_COUNT-1:0] bank_claimed;
  logic                   free_found;
  logic [CH_W-1:0]        free_ch;
  logic [CH_W-1:0]        op_ch;
  logic [CH_W-1:0]        acc_ch;
  logic [SUM_W-1:0]       slot_sum;
  logic [AW-1:0]          mem_addr;
  logic                   ch_ok;
  logic                   scan_last;
  logic                   tick_hit;
  logic                   tick_expire;
  logic                   accept;

  // Write enables and result beat.
  logic             mem_we;
  timer_word_t      mem_wdata;
  logic             en_we, en_val;
  logic             cl_we, cl_val;
  logic             res_fire;
  logic             res_kind;
  logic [CH_W-1:0]  res_ch;
  logic             res_ok;
  logic [TAG_W-1:0] res_tag;
  logic             res_last;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  ostb_period u_period (
    .minutes (min_q),
    .seconds (sec_q),
    .tenths  (tenth_q),
    .period  (period_calc)
  );

  // Lowest free channel of the addressed bank.
  assign bank_claimed = bank_q ? claimed[SLOTS-1 -: TIMER_COUNT] : claimed[TIMER_COUNT-1:0];

  always_comb begin
    free_found = 1'b0;
    free_ch    = '0;
    for (int i = TIMER_COUNT - 1; i >= 0; i--) begin
      if (!bank_claimed[i]) begin
        free_found = 1'b1;
        free_ch    = CH_W'(i);
      end
    end
  end

  // Memory address: the scanned channel during a tick, the lowest free one for a create, else the command's.
  assign op_ch     = (op_q == OP_CREATE) ? free_ch : ch_q;
  assign acc_ch    = (state == S_TRD || state == S_TWR) ? scan_ch : op_ch;
  assign slot_sum  = SUM_W'(acc_ch) + (bank_q ? SUM_W'(TIMER_COUNT) : SUM_W'(0));
  assign mem_addr  = slot_sum[AW-1:0];
  assign ch_ok     = (SUM_W'(ch_q) < SUM_W'(TIMER_COUNT));
  assign scan_last = (scan_ch == CH_W'(TIMER_COUNT - 1));

  // Entries never written read as the reset value.
  assign cur_word    = rd_live ? rd_word : timer_word_t'('0);
  assign tick_hit    = enabled[mem_addr] && claimed[mem_addr] && (cur_word.count != '0);
  assign tick_expire = tick_hit && (cur_word.count == COUNT_W'(1));

  // Sequencer and the modify step of each operation.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_wdata  = cur_word;
    en_we      = 1'b0;
    en_val     = 1'b0;
    cl_we      = 1'b0;
    cl_val     = 1'b0;
    pend_load  = 1'b0;
    res_fire   = 1'b0;
    res_kind   = KIND_CREATE;
    res_ch     = '0;
    res_ok     = 1'b0;
    res_tag    = '0;
    res_last   = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (opcode == OP_TICK) ? S_TRD : S_RD;
        end
      end
      S_RD: begin
        state_next = S_WR;
      end
      S_WR: begin
        state_next = S_IDLE;
        case (op_q)
          OP_CREATE: begin
            res_fire = 1'b1;
            res_last = 1'b1;
            res_ok   = free_found;
            res_ch   = free_found ? free_ch : '0;
            if (free_found) begin
              mem_we        = 1'b1;
              mem_wdata.tag = tag_q;
              cl_we         = 1'b1;
              cl_val        = 1'b1;
            end
          end
          OP_DELETE: begin
            cl_we  = ch_ok;
            cl_val = 1'b0;
          end
          OP_SET: begin
            mem_we           = ch_ok;
            mem_wdata.count  = period_q;
            mem_wdata.reload = period_q;
          end
          OP_START: begin
            en_we  = ch_ok;
            en_val = 1'b1;
          end
          OP_STOP: begin
            en_we  = ch_ok;
            en_val = 1'b0;
          end
          OP_RESET: begin
            mem_we          = ch_ok;
            mem_wdata.count = cur_word.reload;
            en_we           = ch_ok;
            en_val          = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_TRD: begin
        state_next = S_TWR;
      end
      S_TWR: begin
        state_next = scan_last ? S_TEND : S_TRD;
        if (tick_hit) begin
          mem_we          = 1'b1;
          mem_wdata.count = cur_word.count - COUNT_W'(1);
        end
        if (tick_expire) begin
          en_we     = 1'b1;
          en_val    = 1'b0;
          pend_load = 1'b1;
          // A newer expiry releases the held one as a middle beat.
          res_fire  = pend_v;
          res_kind  = KIND_EXPIRY;
          res_ch    = pend_ch;
          res_tag   = pend_tag;
        end
      end
      S_TEND: begin
        state_next = S_IDLE;
        res_fire   = pend_v;
        res_kind   = KIND_EXPIRY;
        res_ch     = pend_ch;
        res_tag    = pend_tag;
        res_last   = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, scan counter and held-beat valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      scan_ch <= '0;
      pend_v  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        scan_ch <= '0;
        pend_v  <= 1'b0;
      end else if (state == S_TWR && !scan_last) begin
        scan_ch <= scan_ch + CH_W'(1);
      end
      if (pend_load) begin
        pend_v <= 1'b1;
      end
    end
  end

  // Command latch, period and held-beat payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= opcode;
      bank_q  <= bank;
      ch_q    <= channel;
      min_q   <= minutes;
      sec_q   <= seconds;
      tenth_q <= tenths;
      tag_q   <= tag;
    end
    if (state == S_RD) begin
      period_q <= period_calc;
    end
    if (pend_load) begin
      pend_ch  <= scan_ch;
      pend_tag <= cur_word.tag;
    end
  end

  // Enable, claim and written flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= '0;
      claimed <= '0;
      written <= '0;
    end else begin
      if (en_we) begin
        enabled[mem_addr] <= en_val;
      end
      if (cl_we) begin
        claimed[mem_addr] <= cl_val;
      end
      if (mem_we) begin
        written[mem_addr] <= 1'b1;
      end
    end
  end

  // Timer memory: one registered read, one write.
  always_ff @(posedge clk) begin
    if (state == S_RD || state == S_TRD) begin
      rd_word <= mem[mem_addr];
      rd_live <= written[mem_addr];
    end
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= res_fire;
    end
    if (res_fire) begin
      kind        <= res_kind;
      out_bank    <= bank_q;
      out_channel <= res_ch;
      ok          <= res_ok;
      out_tag     <= res_tag;
      last        <= res_last;
    end
  end

  // Checks on sequencing and result beats.
  `OSTB_ASSERT_IMPL(a_create_single, clk, rst, strobe && kind == KIND_CREATE, last,
                    "create answer must be the last beat")
  `OSTB_ASSERT_IMPL(a_more_while_busy, clk, rst, strobe && !last, busy,
                    "block went idle with result beats still owed")
  `OSTB_ASSERT_IMPL(a_alloc_in_range, clk, rst, strobe && kind == KIND_CREATE && ok,
                    SUM_W'(out_channel) < SUM_W'(TIMER_COUNT),
                    "allocated channel out of range")
  `OSTB_ASSERT(a_create_answer, clk, rst,
               accept && opcode == OP_CREATE |=> ##2 (strobe && kind == KIND_CREATE),
               "create answer missing")

endmodule
